### rtl/tpt_pkg.sv
// tpt_pkg: shared types, constants and arithmetic helpers of the twiddle tuner
// used by every module of the tuner and by its checker
// no dependencies

package tpt_pkg;

    // number of tuned parameters and the width of their index
    localparam int NUM_TUNED = 3;
    localparam int IDX_W     = 2;

    localparam int PARAM_W   = 32;
    localparam int STEP_W    = 31;
    localparam int METRIC_W  = 48;
    localparam int SAMPLE_W  = 16;
    localparam int COUNT_W   = 16;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VALUE_0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VALUE_1 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VALUE_2 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_STEP_0  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_STEP_1  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_STEP_2  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_LENGTH   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_STEPS = 4'd7;

    // reset values of the configuration registers
    localparam logic [PARAM_W-1:0] RST_INIT_VALUE = 32'd0;
    localparam logic [STEP_W-1:0]  RST_INIT_STEP  = 31'd65536;
    localparam logic [COUNT_W-1:0] RST_RUN_LENGTH = 16'd1000;
    localparam logic [COUNT_W-1:0] RST_SETTLE     = 16'd100;

    // reciprocal of 5 and 10 for 32-bit operands: >>34 gives /5, >>35 gives /10
    localparam logic [31:0] RECIP_5_10  = 32'hCCCC_CCCD;
    localparam logic [31:0] GROW_BIAS   = 32'd5;
    localparam logic [31:0] SHRINK_BIAS = 32'd2;
    localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

    // configuration register file as seen by the datapath
    typedef struct packed {
        logic [NUM_TUNED-1:0][PARAM_W-1:0] init_value;
        logic [NUM_TUNED-1:0][STEP_W-1:0]  init_step;
        logic [COUNT_W-1:0]                run_length;
        logic [COUNT_W-1:0]                settle_steps;
    } t_cfg;

    // end of run notice from the accumulator
    typedef struct packed {
        logic                valid;
        logic [METRIC_W-1:0] metric;
    } t_run_end;

    // saturating add of +step or -2*step to a signed Q16.16 parameter
    function automatic logic [PARAM_W-1:0] sat_add(
        input logic [PARAM_W-1:0] param,
        input logic [STEP_W-1:0]  step,
        input logic               dbl_neg
    );
        logic [PARAM_W+1:0] wide;
        logic [PARAM_W+1:0] delta;
        logic [PARAM_W-1:0] res;
        delta = dbl_neg ? (~{2'b00, step, 1'b0} + 34'd1) : {3'b000, step};
        wide  = {{2{param[PARAM_W-1]}}, param} + delta;
        if (wide[PARAM_W+1:PARAM_W-1] == 3'b000 || wide[PARAM_W+1:PARAM_W-1] == 3'b111) begin
            res = wide[PARAM_W-1:0];
        end else if (wide[PARAM_W+1]) begin
            res = {1'b1, {(PARAM_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(PARAM_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

### rtl/tpt_cfg.sv
// tpt_cfg: configuration registers of the twiddle tuner and restart request
// depends on tpt_pkg

module tpt_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tpt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tpt_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    output tpt_pkg::t_cfg                  o_cfg,
    output logic                           o_restart
);

    tpt_pkg::t_cfg r_cfg;
    logic          r_restart;

    // register writes; a write to any listed register raises the registered restart in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tpt_pkg::NUM_TUNED; i++) begin
                r_cfg.init_value[i] <= tpt_pkg::RST_INIT_VALUE;
                r_cfg.init_step[i]  <= tpt_pkg::RST_INIT_STEP;
            end
            r_cfg.run_length   <= tpt_pkg::RST_RUN_LENGTH;
            r_cfg.settle_steps <= tpt_pkg::RST_SETTLE;
            r_restart          <= 1'b1;
        end else begin
            r_restart <= i_cfg_we && (i_cfg_idx inside {[tpt_pkg::REG_INIT_VALUE_0 :
                                                         tpt_pkg::REG_SETTLE_STEPS]});
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tpt_pkg::REG_INIT_VALUE_0: r_cfg.init_value[0] <= i_cfg_data;
                    tpt_pkg::REG_INIT_VALUE_1: r_cfg.init_value[1] <= i_cfg_data;
                    tpt_pkg::REG_INIT_VALUE_2: r_cfg.init_value[2] <= i_cfg_data;
                    tpt_pkg::REG_INIT_STEP_0:  r_cfg.init_step[0]  <= i_cfg_data[30:0];
                    tpt_pkg::REG_INIT_STEP_1:  r_cfg.init_step[1]  <= i_cfg_data[30:0];
                    tpt_pkg::REG_INIT_STEP_2:  r_cfg.init_step[2]  <= i_cfg_data[30:0];
                    tpt_pkg::REG_RUN_LENGTH:   r_cfg.run_length    <= i_cfg_data[15:0];
                    tpt_pkg::REG_SETTLE_STEPS: r_cfg.settle_steps  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_cfg     = r_cfg;
    assign o_restart = r_restart;

endmodule

### rtl/tpt_accum.sv
// tpt_accum: step counter, sample register and squared error accumulator
// depends on tpt_pkg

module tpt_accum (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tpt_pkg::t_cfg                 i_cfg,
    input  logic                          i_restart,
    input  logic                          i_accept,
    input  logic [tpt_pkg::SAMPLE_W-1:0]  i_error_sample,
    output tpt_pkg::t_run_end             o_run_end
);

    logic [tpt_pkg::COUNT_W-1:0]  r_count;
    logic                         r_v;
    logic                         r_end;
    logic                         r_sum_en;
    logic [tpt_pkg::SAMPLE_W-1:0] r_sample;
    logic [tpt_pkg::METRIC_W-1:0] r_sum;

    logic [tpt_pkg::COUNT_W:0]    w_c;
    logic [tpt_pkg::COUNT_W:0]    w_c2;
    logic                         w_end;
    logic                         w_sum_en;
    logic signed [31:0]           w_sq;

    // position of this transaction within the run
    always_comb begin
        w_c      = {1'b0, r_count} + 17'd1;
        w_c2     = w_c + 17'd2;
        w_end    = (w_c >= {1'b0, i_cfg.run_length});
        w_sum_en = !w_end && (w_c >= {1'b0, i_cfg.settle_steps})
                   && (w_c2 <= {1'b0, i_cfg.run_length});
    end

    // counter and input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_count <= '0;
            r_v     <= 1'b0;
        end else begin
            r_v <= i_accept;
            if (i_accept) begin
                r_count <= w_end ? '0 : w_c[tpt_pkg::COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_sample <= i_error_sample;
            r_end    <= w_end;
            r_sum_en <= w_sum_en;
        end
    end

    // square of the registered sample
    assign w_sq = $signed(r_sample) * $signed(r_sample);

    // running sum, cleared when the run ends
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_sum <= '0;
        end else if (r_v && r_end) begin
            r_sum <= '0;
        end else if (r_v && r_sum_en) begin
            r_sum <= r_sum + {16'd0, w_sq};
        end
    end

    assign o_run_end.valid  = r_v && r_end;
    assign o_run_end.metric = r_sum;

endmodule

### rtl/tpt_core.sv
// tpt_core: parameter and step stores, twiddle update sequencer, result register
// depends on tpt_pkg

module tpt_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tpt_pkg::t_cfg                   i_cfg,
    input  logic                            i_restart,
    input  tpt_pkg::t_run_end               i_run_end,
    input  logic                            i_out_stall,
    output logic                            o_busy,
    output logic                            o_out_valid,
    output logic [tpt_pkg::IDX_W-1:0]       o_param_index,
    output logic [tpt_pkg::PARAM_W-1:0]     o_param_value,
    output logic [tpt_pkg::STEP_W-1:0]      o_step_size,
    output logic [tpt_pkg::METRIC_W-1:0]    o_run_metric,
    output logic                            o_is_last
);

    typedef enum logic [4:0] {
        ST_RUN  = 5'b00001,
        ST_CALC = 5'b00010,
        ST_ADJ  = 5'b00100,
        ST_BUMP = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        UPD_FIRST   = 2'd0,
        UPD_BETTER  = 2'd1,
        UPD_UP_FAIL = 2'd2,
        UPD_DN_FAIL = 2'd3
    } t_upd;

    localparam logic [tpt_pkg::IDX_W-1:0] LAST_IDX = tpt_pkg::IDX_W'(tpt_pkg::NUM_TUNED - 1);

    t_state r_state, n_state;
    t_upd   r_upd;

    logic [tpt_pkg::PARAM_W-1:0]  r_param [tpt_pkg::NUM_TUNED];
    logic [tpt_pkg::STEP_W-1:0]   r_step  [tpt_pkg::NUM_TUNED];
    logic [tpt_pkg::METRIC_W-1:0] r_best;
    logic [tpt_pkg::METRIC_W-1:0] r_metric;
    logic                         r_first;
    logic                         r_tried_inc;
    logic [tpt_pkg::IDX_W-1:0]    r_k;
    logic [tpt_pkg::IDX_W-1:0]    r_oidx;
    logic [63:0]                  r_prod;

    logic                         r_ovalid;
    logic [tpt_pkg::IDX_W-1:0]    r_o_idx;
    logic [tpt_pkg::PARAM_W-1:0]  r_o_param;
    logic [tpt_pkg::STEP_W-1:0]   r_o_step;
    logic [tpt_pkg::METRIC_W-1:0] r_o_metric;
    logic                         r_o_last;

    logic [tpt_pkg::IDX_W-1:0]    w_ridx;
    logic [tpt_pkg::PARAM_W-1:0]  w_param;
    logic [tpt_pkg::STEP_W-1:0]   w_step;
    logic [tpt_pkg::IDX_W-1:0]    w_knext;
    logic                         w_better;
    logic [31:0]                  w_mul_in;
    logic [31:0]                  w_grow;
    logic [tpt_pkg::STEP_W-1:0]   w_grow_sat;
    logic [tpt_pkg::STEP_W-1:0]   w_shrink;
    logic                         w_load;

    // single read port: output index during the burst, tuned index otherwise
    always_comb begin
        w_ridx  = (r_state == ST_OUT) ? r_oidx : r_k;
        w_param = r_param[w_ridx];
        w_step  = r_step[w_ridx];
        w_knext = (r_k == LAST_IDX) ? '0 : r_k + 1'b1;
    end

    // step grow by 1.1 and shrink by 0.8, rounding half up
    always_comb begin
        w_better   = (r_metric < r_best);
        w_mul_in   = {1'b0, w_step} + (w_better ? tpt_pkg::GROW_BIAS : tpt_pkg::SHRINK_BIAS);
        w_grow     = {1'b0, w_step} + {3'b000, r_prod[63:35]};
        w_grow_sat = w_grow[31] ? tpt_pkg::STEP_MAX : w_grow[30:0];
        w_shrink   = w_step - {1'b0, r_prod[63:34]};
    end

    // result register is free or being taken
    assign w_load = (r_state == ST_OUT) && (!r_ovalid || !i_out_stall);

    // sequencer state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_RUN:  if (i_run_end.valid) n_state = ST_CALC;
            ST_CALC: n_state = ST_ADJ;
            ST_ADJ:  n_state = ST_BUMP;
            ST_BUMP: n_state = ST_OUT;
            ST_OUT:  if (w_load && r_oidx == LAST_IDX) n_state = ST_RUN;
            default: n_state = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    // twiddle control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_best      <= {tpt_pkg::METRIC_W{1'b1}};
            r_first     <= 1'b1;
            r_tried_inc <= 1'b1;
            r_k         <= '0;
            r_oidx      <= '0;
        end else begin
            case (r_state)
                ST_CALC: begin
                    if (r_first) begin
                        r_best  <= r_metric;
                        r_first <= 1'b0;
                    end else if (w_better) begin
                        r_best <= r_metric;
                    end else if (r_tried_inc) begin
                        r_tried_inc <= 1'b0;
                    end
                end
                ST_ADJ: begin
                    case (r_upd)
                        UPD_FIRST:   r_k <= '0;
                        UPD_BETTER:  r_k <= w_knext;
                        UPD_DN_FAIL: r_k <= w_knext;
                        default:     r_k <= r_k;
                    endcase
                end
                ST_BUMP: begin
                    if (r_upd != UPD_UP_FAIL) r_tried_inc <= 1'b1;
                    r_oidx <= '0;
                end
                ST_OUT: begin
                    if (w_load) r_oidx <= r_oidx + 1'b1;
                end
                default: r_oidx <= r_oidx;
            endcase
        end
    end

    // update kind, run metric and reciprocal product
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RUN && i_run_end.valid) begin
            r_metric <= i_run_end.metric;
        end
        if (r_state == ST_CALC) begin
            if (r_first) begin
                r_upd <= UPD_FIRST;
            end else if (w_better) begin
                r_upd <= UPD_BETTER;
            end else if (r_tried_inc) begin
                r_upd <= UPD_UP_FAIL;
            end else begin
                r_upd <= UPD_DN_FAIL;
            end
            r_prod <= w_mul_in * tpt_pkg::RECIP_5_10;
        end
    end

    // parameter and step stores
    always_ff @(posedge i_clk) begin
        if (i_restart) begin
            for (int i = 0; i < tpt_pkg::NUM_TUNED; i++) begin
                r_param[i] <= i_cfg.init_value[i];
                r_step[i]  <= i_cfg.init_step[i];
            end
        end else begin
            case (r_state)
                ST_CALC: begin
                    if (!r_first && !w_better) begin
                        r_param[r_k] <= tpt_pkg::sat_add(w_param, w_step, r_tried_inc);
                    end
                end
                ST_ADJ: begin
                    if (r_upd == UPD_BETTER) begin
                        r_step[r_k] <= w_grow_sat;
                    end else if (r_upd == UPD_DN_FAIL) begin
                        r_step[r_k] <= w_shrink;
                    end
                end
                ST_BUMP: begin
                    if (r_upd != UPD_UP_FAIL) begin
                        r_param[r_k] <= tpt_pkg::sat_add(w_param, w_step, 1'b0);
                    end
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_idx    <= r_oidx;
            r_o_param  <= w_param;
            r_o_step   <= w_step;
            r_o_metric <= r_metric;
            r_o_last   <= (r_oidx == LAST_IDX);
        end
    end

    assign o_busy        = (r_state != ST_RUN);
    assign o_out_valid   = r_ovalid;
    assign o_param_index = r_o_idx;
    assign o_param_value = r_o_param;
    assign o_step_size   = r_o_step;
    assign o_run_metric  = r_o_metric;
    assign o_is_last     = r_o_last;

endmodule

### rtl/twiddle_parameter_tuner_top.sv
// twiddle_parameter_tuner_top: top level of the twiddle coordinate descent tuner
// depends on tpt_pkg, tpt_cfg, tpt_accum, tpt_core

// The tuner takes one signed Q8.8 error sample per transaction and accepts a
// new sample every clock cycle while a run is in progress; samples of step
// settle_steps up to run_length-2 are squared and summed into a 48-bit metric.
// The sample that ends a run is not summed: it triggers a twiddle update that
// runs through a short sequencer (ST_RUN catches the end, then the update
// states ST_CALC, ST_ADJ and ST_BUMP share a single 32x32 reciprocal
// multiplier for the step grow/shrink) and then three results, one per
// parameter in index order, leave through the output register, the last
// one flagged with is_last. The input is stalled from the cycle after the
// end sample until the last result is loaded, through the update states and
// the output transactions, also while the output side stalls. Any write to
// a listed configuration register, and reset, reloads all tuner state from
// the registers in the following cycle, during which the input is stalled.

module twiddle_parameter_tuner_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tpt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tpt_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [tpt_pkg::SAMPLE_W-1:0]   i_error_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [tpt_pkg::IDX_W-1:0]      o_param_index,
    output logic [tpt_pkg::PARAM_W-1:0]    o_param_value,
    output logic [tpt_pkg::STEP_W-1:0]     o_step_size,
    output logic [tpt_pkg::METRIC_W-1:0]   o_run_metric,
    output logic                           o_is_last
);

    tpt_pkg::t_cfg     w_cfg;
    tpt_pkg::t_run_end w_run_end;
    logic              w_restart;
    logic              w_busy;
    logic              w_accept;

    // input transaction flow control
    assign o_in_stall = w_restart || w_busy || w_run_end.valid;
    assign w_accept   = i_in_valid && !o_in_stall;

    tpt_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg),
        .o_restart  (w_restart)
    );

    tpt_accum u_accum (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_restart      (w_restart),
        .i_accept       (w_accept),
        .i_error_sample (i_error_sample),
        .o_run_end      (w_run_end)
    );

    tpt_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_restart     (w_restart),
        .i_run_end     (w_run_end),
        .i_out_stall   (i_out_stall),
        .o_busy        (w_busy),
        .o_out_valid   (o_out_valid),
        .o_param_index (o_param_index),
        .o_param_value (o_param_value),
        .o_step_size   (o_step_size),
        .o_run_metric  (o_run_metric),
        .o_is_last     (o_is_last)
    );

endmodule

### rtl/tpt_checker.sv
// tpt_checker: port-level checks of the twiddle tuner, bound to the top level
// depends on tpt_pkg and twiddle_parameter_tuner_top

module tpt_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           o_in_stall,
    input  logic                           o_out_valid,
    input  logic                           i_out_stall,
    input  logic [tpt_pkg::IDX_W-1:0]      o_param_index,
    input  logic [tpt_pkg::PARAM_W-1:0]    o_param_value,
    input  logic [tpt_pkg::STEP_W-1:0]     o_step_size,
    input  logic [tpt_pkg::METRIC_W-1:0]   o_run_metric,
    input  logic                           o_is_last
);

    localparam logic [tpt_pkg::IDX_W-1:0] LAST_IDX = tpt_pkg::IDX_W'(tpt_pkg::NUM_TUNED - 1);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_param_index)
        && $stable(o_param_value) && $stable(o_step_size) && $stable(o_run_metric)
        && $stable(o_is_last))
        else $error("stalled result changed");

    // last flag only on the highest parameter index
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_last == (o_param_index == LAST_IDX)))
        else $error("is_last does not match parameter index");

    // burst results follow each other in index order with no gap
    a_burst_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_is_last |=> o_out_valid
        && o_param_index == $past(o_param_index) + 1'b1
        && o_run_metric == $past(o_run_metric))
        else $error("burst out of order");

    // no sample is taken in the middle of a burst
    a_burst_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_last |-> o_in_stall)
        else $error("input accepted during result burst");

endmodule

bind twiddle_parameter_tuner_top tpt_checker u_tpt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_param_index (o_param_index),
    .o_param_value (o_param_value),
    .o_step_size   (o_step_size),
    .o_run_metric  (o_run_metric),
    .o_is_last     (o_is_last)
);
